>>> sv/bc1_pkg.sv
// bc1_pkg: shared types and constants for the BC1 block decoder.
// Used by bc1_front, bc1_fifo, bc1_back and bc1_block_decoder_core; no dependencies.
`timescale 1ns / 1ps

package bc1_pkg;

   localparam int TEXELS_PER_BLOCK = 4 * 4;
   localparam int TEXEL_CNT_W      = $clog2(TEXELS_PER_BLOCK);
   localparam int PALETTE_SIZE     = 4;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;
   localparam logic [7:0] ALPHA_TRANSPARENT = 8'h00;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

   // One decoded block: resolved palette plus the raw 2-bit indices.
   typedef struct packed {
      color_type [PALETTE_SIZE-1:0] palette;
      logic [31:0]                  index_bits;
   } entry_type;

endpackage

>>> sv/bc1_front.sv
// bc1_front: accepts a BC1 block, expands the RGB565 endpoints and builds the palette.
// Depends on bc1_pkg; feeds bc1_fifo.
`timescale 1ns / 1ps

module bc1_front
   import bc1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_endpoint_zero,
   input  logic [15:0] req_endpoint_one,
   input  logic [31:0] req_index_bits,
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_entry
);

   // v*255/31 and v*255/63 as a multiply by a scaled reciprocal, exact over the input range.
   localparam int          WIDEN5_SHIFT = 18;
   localparam logic [26:0] WIDEN5_MUL   = 27'd2156535;
   localparam int          WIDEN6_SHIFT = 20;
   localparam logic [28:0] WIDEN6_MUL   = 29'd4244475;
   // x/3 for x below 2048.
   localparam int          THIRD_SHIFT  = 11;
   localparam logic [19:0] THIRD_MUL    = 20'd683;

   typedef struct packed {
      color_type   end0;
      color_type   end1;
      logic        four_color;
      logic [31:0] index_bits;
   } stage_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [26:0] p;
      p = 27'(v) * WIDEN5_MUL;
      return p[WIDEN5_SHIFT +: 8];
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [28:0] p;
      p = 29'(v) * WIDEN6_MUL;
      return p[WIDEN6_SHIFT +: 8];
   endfunction

   // (2a + b + 1) / 3
   function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
      logic [9:0]  s;
      logic [19:0] p;
      s = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
      p = 20'(s) * THIRD_MUL;
      return p[THIRD_SHIFT +: 8];
   endfunction

   function automatic color_type expand(input logic [15:0] c);
      color_type r;
      r.red   = widen5(c[15:11]);
      r.green = widen6(c[10:5]);
      r.blue  = widen5(c[4:0]);
      r.alpha = ALPHA_OPAQUE;
      return r;
   endfunction

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      s1_load;
   logic      accept;

   assign s1_load   = !s1_valid_ff || push_ready;
   assign req_stall = !s1_load;
   assign accept    = req_valid && s1_load;

   always_comb begin
      s1_valid_in = s1_load ? req_valid : s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_in.end0       = expand(req_endpoint_zero);
         s1_in.end1       = expand(req_endpoint_one);
         s1_in.four_color = req_endpoint_zero > req_endpoint_one;
         s1_in.index_bits = req_index_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // Palette from the registered endpoints.
   always_comb begin
      push_entry.palette[0] = s1_ff.end0;
      push_entry.palette[1] = s1_ff.end1;
      if (s1_ff.four_color) begin
         push_entry.palette[2].red   = third(s1_ff.end0.red,   s1_ff.end1.red);
         push_entry.palette[2].green = third(s1_ff.end0.green, s1_ff.end1.green);
         push_entry.palette[2].blue  = third(s1_ff.end0.blue,  s1_ff.end1.blue);
         push_entry.palette[2].alpha = ALPHA_OPAQUE;
         push_entry.palette[3].red   = third(s1_ff.end1.red,   s1_ff.end0.red);
         push_entry.palette[3].green = third(s1_ff.end1.green, s1_ff.end0.green);
         push_entry.palette[3].blue  = third(s1_ff.end1.blue,  s1_ff.end0.blue);
         push_entry.palette[3].alpha = ALPHA_OPAQUE;
      end else begin
         push_entry.palette[2].red   = 8'((9'(s1_ff.end0.red)   + 9'(s1_ff.end1.red))   >> 1);
         push_entry.palette[2].green = 8'((9'(s1_ff.end0.green) + 9'(s1_ff.end1.green)) >> 1);
         push_entry.palette[2].blue  = 8'((9'(s1_ff.end0.blue)  + 9'(s1_ff.end1.blue))  >> 1);
         push_entry.palette[2].alpha = ALPHA_OPAQUE;
         push_entry.palette[3].red   = 8'd0;
         push_entry.palette[3].green = 8'd0;
         push_entry.palette[3].blue  = 8'd0;
         push_entry.palette[3].alpha = ALPHA_TRANSPARENT;
      end
      push_entry.index_bits = s1_ff.index_bits;
   end

   assign push_valid = s1_valid_ff;

endmodule

>>> sv/bc1_fifo.sv
// bc1_fifo: short queue of decoded palettes between front and back.
// Depends on bc1_pkg (entry_type, FIFO_DEPTH).
`timescale 1ns / 1ps

module bc1_fifo
   import bc1_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type               entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    push;
   logic                    pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   // Pointers wrap naturally: the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("fifo count beyond depth");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FIFO_CNT_W'(FIFO_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("fifo pointers disagree with count");

   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (!push_ready && !pop_ready) |=> !push_ready)
      else $error("full fifo drained without a pop");

endmodule

>>> sv/bc1_back.sv
// bc1_back: walks the sixteen texels of the queued block and drives the result register.
// Depends on bc1_pkg; reads the head of bc1_fifo.
`timescale 1ns / 1ps

module bc1_back
   import bc1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_entry,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   output logic [1:0] rsp_texel_x,
   output logic [1:0] rsp_texel_y,
   output logic       rsp_last_texel
);

   localparam logic [TEXEL_CNT_W-1:0] LAST_TEXEL = TEXEL_CNT_W'(TEXELS_PER_BLOCK - 1);

   typedef struct packed {
      color_type  color;
      logic [1:0] texel_x;
      logic [1:0] texel_y;
      logic       last_texel;
   } texel_type;

   logic                   rsp_valid_ff, rsp_valid_in;
   texel_type              rsp_ff, rsp_in;
   logic [TEXEL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   advance;
   logic                   emit;
   logic [1:0]             index;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign emit      = advance && pop_valid;
   assign pop_ready = emit && cnt_ff == LAST_TEXEL;
   assign index     = 2'(pop_entry.index_bits >> {cnt_ff, 1'b0});

   always_comb begin
      rsp_valid_in = advance ? pop_valid : rsp_valid_ff;
      cnt_in       = emit ? cnt_ff + TEXEL_CNT_W'(1) : cnt_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.color      = pop_entry.palette[index];
         rsp_in.texel_x    = cnt_ff[1:0];
         rsp_in.texel_y    = cnt_ff[3:2];
         rsp_in.last_texel = cnt_ff == LAST_TEXEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_ff.color.red;
   assign rsp_green      = rsp_ff.color.green;
   assign rsp_blue       = rsp_ff.color.blue;
   assign rsp_alpha      = rsp_ff.color.alpha;
   assign rsp_texel_x    = rsp_ff.texel_x;
   assign rsp_texel_y    = rsp_ff.texel_y;
   assign rsp_last_texel = rsp_ff.last_texel;

   a_last_corner : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_texel) |-> (rsp_texel_x == 2'd3 && rsp_texel_y == 2'd3))
      else $error("last texel not at block corner");

   a_count_follows : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && {rsp_texel_y, rsp_texel_x} != LAST_TEXEL) |-> cnt_ff != '0)
      else $error("texel counter out of step with result");

   a_transparent_black : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alpha != ALPHA_OPAQUE) |->
      (rsp_alpha == ALPHA_TRANSPARENT && rsp_red == 8'd0 && rsp_green == 8'd0 &&
       rsp_blue == 8'd0))
      else $error("non-opaque texel is not transparent black");

endmodule

>>> sv/bc1_block_decoder_core.sv
// bc1_block_decoder_core: BC1 block decoder top level, sixteen RGBA texels per block.
// Depends on bc1_pkg, bc1_front, bc1_fifo and bc1_back.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  endpoint_zero, endpoint_one, index_bits
//   rsp_     out        rsp_valid/rsp_stall  red, green, blue, alpha, texel_x, texel_y, last_texel
//
// The texel counter emits one texel per cycle while a block is queued and rsp_ is not stalled.
// Without stalls the first texel reaches rsp_ via the front, queue entry and result registers.
// Reset is synchronous, active high, and clears the valid flags, queue and counter.
// A stall on rsp_ holds the result register; the queue lets the front keep taking
// blocks until it fills, and only then does req_stall rise.
`timescale 1ns / 1ps

module bc1_block_decoder_core
   import bc1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_endpoint_zero,
   input  logic [15:0] req_endpoint_one,
   input  logic [31:0] req_index_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [1:0]  rsp_texel_x,
   output logic [1:0]  rsp_texel_y,
   output logic        rsp_last_texel
);

   // Front to queue: palette of the registered block.
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // Queue to back: head block, popped on its last texel.
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // Expand endpoints on transfer, build the palette one stage later.
   bc1_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_endpoint_zero (req_endpoint_zero),
      .req_endpoint_one  (req_endpoint_one),
      .req_index_bits    (req_index_bits),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   // Hold decoded palettes so front and back stall independently.
   bc1_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Walk texels in raster order, one per result transfer.
   bc1_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_texel_x    (rsp_texel_x),
      .rsp_texel_y    (rsp_texel_y),
      .rsp_last_texel (rsp_last_texel)
   );

endmodule
